[src/dnc_pkg.sv]
// Shared types and constants for the decimated normalized correlation block.
// No dependencies.
`default_nettype none
package dnc_pkg;
    localparam int ACC_W = 64;
    localparam int Q_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    typedef struct packed {
        logic [ACC_W-1:0] sum_a;
        logic [ACC_W-1:0] sum_b;
        logic [ACC_W-1:0] sum_c;
    } dnc_job_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_PREP,
        BE_SEARCH,
        BE_MUL,
        BE_CMP,
        BE_OUT
    } dnc_be_state_t;
endpackage
`default_nettype wire

[src/dnc_mpmul.sv]
// Sequential unsigned multiplier, 32x32 partial products, one per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module dnc_mpmul #(
    parameter int A_W = 128,
    parameter int B_W = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic                      done,
    output logic [A_W+B_W-1:0]        product
);
    localparam int NA = (A_W + 31) / 32;
    localparam int NB = (B_W + 31) / 32;
    localparam int NP = NA * NB;
    localparam int CW = $clog2(NP + 1);
    localparam int IW = (NA > 1) ? $clog2(NA) : 1;
    localparam int JW = (NB > 1) ? $clog2(NB) : 1;
    localparam int PW = A_W + B_W;

    logic [NA*32-1:0] a_reg;
    logic [NB*32-1:0] b_reg;
    logic [PW-1:0]    acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic [IW-1:0]    i_reg;
    logic [JW-1:0]    j_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      pp;
    logic [PW+63:0]   shifted;

    always_comb begin
        pp = {32'd0, a_reg[i_reg*32 +: 32]} * {32'd0, b_reg[j_reg*32 +: 32]};
        shifted = {{PW{1'b0}}, pp} << ((PW + 64)'(i_reg) * 32 + (PW + 64)'(j_reg) * 32);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= (NA*32)'(a);
                b_reg    <= (NB*32)'(b);
                acc_reg  <= '0;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                i_reg    <= '0;
                j_reg    <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_reg + shifted[PW-1:0];
                if (cnt_reg == CW'(NP - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (j_reg == JW'(NB - 1)) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

[src/dnc_front.sv]
// Front end: decimation phase and saturating multiply-accumulate.
// Depends on dnc_pkg.
`default_nettype none
module dnc_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [15:0]             cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [23:0]             s_long_sample,
    input  wire logic [23:0]             s_short_sample,
    input  wire logic                    s_last_item,
    output logic                         job_valid,
    input  wire logic                    job_ready,
    output dnc_pkg::dnc_job_t            job
);
    import dnc_pkg::*;

    localparam int PRODUCT_W = 2 * SAMPLE_BITS;

    logic [15:0]      ratio_reg;
    logic [15:0]      phase_reg;
    logic [ACC_W-1:0] sa_reg, sb_reg, sc_reg;
    logic             p_valid_reg, p_last_reg, p_use_reg;
    logic [PRODUCT_W-1:0] pa_reg, pb_reg, pc_reg;
    logic             j_valid_reg;
    dnc_job_t         j_reg;
    logic [SAMPLE_BITS-1:0] ls, ss;
    logic [15:0]      step, phase_inc;
    logic [ACC_W:0]   na, nb, nc;
    logic [ACC_W-1:0] fa, fb, fc;
    logic             stall;

    assign ls = s_long_sample[SAMPLE_BITS-1:0];
    assign ss = s_short_sample[SAMPLE_BITS-1:0];
    assign step = (ratio_reg == 16'd0) ? 16'd1 : ratio_reg;
    assign phase_inc = phase_reg + 16'd1;
    assign stall = j_valid_reg && !job_ready;
    assign s_ready = !stall;

    always_comb begin
        na = {1'b0, sa_reg} + (ACC_W + 1)'(pa_reg);
        nb = {1'b0, sb_reg} + (ACC_W + 1)'(pb_reg);
        nc = {1'b0, sc_reg} + (ACC_W + 1)'(pc_reg);
        fa = na[ACC_W] ? '1 : na[ACC_W-1:0];
        fb = nb[ACC_W] ? '1 : nb[ACC_W-1:0];
        fc = nc[ACC_W] ? '1 : nc[ACC_W-1:0];
        if (!p_use_reg) begin
            fa = sa_reg;
            fb = sb_reg;
            fc = sc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg   <= 16'd1;
            phase_reg   <= '0;
            sa_reg      <= '0;
            sb_reg      <= '0;
            sc_reg      <= '0;
            p_valid_reg <= 1'b0;
            p_use_reg   <= 1'b0;
            p_last_reg  <= 1'b0;
            j_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                ratio_reg <= cfg_wdata;
            end
            if (!stall && p_valid_reg && p_last_reg) begin
                j_valid_reg <= 1'b1;
            end else if (job_ready) begin
                j_valid_reg <= 1'b0;
            end
            if (!stall) begin
                if (p_valid_reg) begin
                    if (p_last_reg) begin
                        j_reg.sum_a <= fa;
                        j_reg.sum_b <= fb;
                        j_reg.sum_c <= fc;
                        sa_reg <= '0;
                        sb_reg <= '0;
                        sc_reg <= '0;
                    end else begin
                        sa_reg <= fa;
                        sb_reg <= fb;
                        sc_reg <= fc;
                    end
                end
                p_valid_reg <= s_valid;
                if (s_valid) begin
                    p_use_reg  <= (phase_reg == 16'd0);
                    p_last_reg <= s_last_item;
                    pa_reg <= PRODUCT_W'(ls) * PRODUCT_W'(ls);
                    pb_reg <= PRODUCT_W'(ss) * PRODUCT_W'(ss);
                    pc_reg <= PRODUCT_W'(ls) * PRODUCT_W'(ss);
                    if (s_last_item || phase_inc >= step) begin
                        phase_reg <= '0;
                    end else begin
                        phase_reg <= phase_inc;
                    end
                end
            end
        end
    end

    assign job_valid = j_valid_reg;
    assign job = j_reg;
endmodule
`default_nettype wire

[src/dnc_queue.sv]
// Short FIFO of accumulated sums between front and back end.
// Depends on dnc_pkg.
`default_nettype none
module dnc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  dnc_pkg::dnc_job_t  in_job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dnc_pkg::dnc_job_t  out_job
);
    import dnc_pkg::*;

    dnc_job_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic              push, pop;

    assign in_ready = (cnt_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_job = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
        end
    end
endmodule
`default_nettype wire

[src/dnc_back.sv]
// Back end: binary search for q with q*q*A*B <= C*C*2^30, via a shared multiplier.
// Depends on dnc_pkg and dnc_mpmul.
`default_nettype none
module dnc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  dnc_pkg::dnc_job_t  job,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic signed [15:0] m_correlation,
    output logic               m_degenerate
);
    import dnc_pkg::*;

    dnc_be_state_t state_reg, state_next;
    dnc_job_t      job_reg;
    logic [1:0]    prep_reg;
    logic [2*ACC_W-1:0] ab_reg, cc_reg;
    logic [14:0]   lo_reg, hi_reg;
    logic [15:0]   mid;
    logic [29:0]   mid_sq_reg;
    logic          mul_start;
    logic [2*ACC_W-1:0] mul_a;
    logic [ACC_W-1:0]   mul_b;
    logic          mul_done;
    logic [3*ACC_W-1:0] mul_p;
    logic [3*ACC_W-1:0] rhs;
    logic          le;
    logic          out_valid_reg, out_deg_reg;
    logic [15:0]   out_q_reg;

    dnc_mpmul #(.A_W(2 * ACC_W), .B_W(ACC_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
    );

    assign mid = ({1'b0, lo_reg} + {1'b0, hi_reg} + 16'd1) >> 1;
    assign rhs = {{ACC_W{1'b0}}, cc_reg} << 30;
    assign le = (mul_p <= rhs);

    always_comb begin
        state_next = state_reg;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        job_ready = 1'b0;
        case (state_reg)
            BE_IDLE: begin
                if (!out_valid_reg) begin
                    job_ready = 1'b1;
                    if (job_valid) state_next = BE_PREP;
                end
            end
            BE_PREP: begin
                if (job_reg.sum_a == '0 || job_reg.sum_b == '0) begin
                    state_next = BE_OUT;
                end else if (prep_reg == 2'd0) begin
                    mul_start = 1'b1;
                    mul_a = {{ACC_W{1'b0}}, job_reg.sum_c};
                    mul_b = job_reg.sum_c;
                end else if (prep_reg == 2'd2) begin
                    mul_start = 1'b1;
                    mul_a = {{ACC_W{1'b0}}, job_reg.sum_a};
                    mul_b = job_reg.sum_b;
                end else if (prep_reg == 2'd3 && mul_done) begin
                    state_next = BE_SEARCH;
                end
            end
            BE_SEARCH: begin
                if (lo_reg == hi_reg) state_next = BE_OUT;
                else state_next = BE_MUL;
            end
            BE_MUL: begin
                mul_start = 1'b1;
                mul_a = ab_reg;
                mul_b = {{(ACC_W-30){1'b0}}, mid_sq_reg};
                state_next = BE_CMP;
            end
            BE_CMP: begin
                if (mul_done) state_next = BE_SEARCH;
            end
            BE_OUT: state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            out_valid_reg <= 1'b0;
            prep_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                BE_IDLE: begin
                    job_reg  <= job;
                    prep_reg <= '0;
                    lo_reg   <= '0;
                    hi_reg   <= 15'h7FFF;
                end
                BE_PREP: begin
                    if (prep_reg == 2'd0) prep_reg <= 2'd1;
                    else if (prep_reg == 2'd1 && mul_done) begin
                        cc_reg   <= mul_p[2*ACC_W-1:0];
                        prep_reg <= 2'd2;
                    end else if (prep_reg == 2'd2) prep_reg <= 2'd3;
                    else if (prep_reg == 2'd3 && mul_done) ab_reg <= mul_p[2*ACC_W-1:0];
                end
                BE_SEARCH: mid_sq_reg <= 30'(mid) * 30'(mid);
                BE_CMP: begin
                    if (mul_done) begin
                        if (le) lo_reg <= mid[14:0];
                        else hi_reg <= mid[14:0] - 15'd1;
                    end
                end
                BE_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_deg_reg   <= (job_reg.sum_a == '0 || job_reg.sum_b == '0);
                    out_q_reg     <= (job_reg.sum_a == '0 || job_reg.sum_b == '0)
                                     ? 16'd0 : {1'b0, lo_reg};
                end
                default: ;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_correlation = out_q_reg;
    assign m_degenerate = out_deg_reg;
endmodule
`default_nettype wire

[src/decimated_normalized_correlation.sv]
// Decimated normalized correlation: top level.
// Channels: s_ (long_sample, short_sample, last_item) valid/ready, m_ (correlation,
// degenerate) valid/ready; cfg_we/cfg_wdata write the 16-bit decimation ratio.
// Throughput: one input transaction per cycle while s_ready is high; the front end is a
// two-stage multiply-accumulate with saturating 64-bit sums.
// A transaction with last_item hands the three sums to a 4-entry queue; the back
// end forms C*C and A*B, then runs a 15-step binary search, each product a 128x64
// multiply built from eight 32x32 partial products on one shared multiplier.
// When a sum of squares is zero the multiplies are skipped and m_degenerate is
// set with a zero correlation; the back end takes one queued job at a time, and
// only after the previous result has been accepted on m_ready.
// The front keeps streaming while the queue has room; a stalled m_ready backs up
// the queue and then s_ready.
// Reset (aresetn, synchronous) clears sums, phase, queue and sets ratio to 1.
// Depends on dnc_pkg, dnc_front, dnc_queue, dnc_back, dnc_mpmul.
`default_nettype none
module decimated_normalized_correlation #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [23:0]        s_long_sample,
    input  wire logic [23:0]        s_short_sample,
    input  wire logic               s_last_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_correlation,
    output logic                    m_degenerate
);
    import dnc_pkg::*;

    logic     f_valid, f_ready, q_valid, q_ready;
    dnc_job_t f_job, q_job;

    dnc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_long_sample(s_long_sample),
        .s_short_sample(s_short_sample), .s_last_item(s_last_item),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    dnc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(f_valid), .in_ready(f_ready),
        .in_job(f_job), .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    dnc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(q_valid), .job_ready(q_ready),
        .job(q_job), .m_valid(m_valid), .m_ready(m_ready),
        .m_correlation(m_correlation), .m_degenerate(m_degenerate)
    );
endmodule
`default_nettype wire
